// ----- rtl/core/spl_pkg.sv -----
// Shared constants and types for the striped parity layout locator.
package spl_pkg;

  // Field and register widths
  localparam int NC_W   = 7;
  localparam int BS_W   = 31;
  localparam int CI_W   = 6;
  localparam int CFG_W  = 31;
  localparam int IDX_W  = 2;

  // Offset width default and division bits retired per pipeline stage
  localparam int OFFSET_WIDTH_DEF = 64;
  localparam int DIV_BPS          = 8;

  // Register reset values and component count limits
  localparam logic [NC_W-1:0] RESET_COMPONENTS = NC_W'(2);
  localparam logic [NC_W-1:0] MIN_COMPONENTS   = NC_W'(2);
  localparam logic [NC_W-1:0] MAX_COMPONENTS   = NC_W'(64);
  localparam logic [BS_W-1:0] RESET_BLOCK_SIZE = BS_W'(64 << 10);

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_NUM_COMPONENTS = 2'd0,
    REG_BLOCK_SIZE     = 2'd1
  } reg_index_t;

endpackage

// ----- rtl/core/spl_div.sv -----
// Pipelined restoring divider, BPS quotient bits per stage, with sideband.
module spl_div #(
  parameter int NW  = 64,
  parameter int DW  = 31,
  parameter int BPS = 8,
  parameter int SW  = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [SW-1:0] in_side,
  input  logic [DW-1:0] div,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [DW-1:0] out_rem,
  output logic [SW-1:0] out_side
);

  localparam int NS = (NW + BPS - 1) / BPS;
  localparam int PW = NS * BPS;

  logic [NS-1:0] v;
  logic [PW-1:0] wk   [NS];
  logic [DW-1:0] rm   [NS];
  logic [SW-1:0] sd   [NS];
  logic [PW-1:0] wk_next [NS];
  logic [DW-1:0] rm_next [NS];

  // Each stage shifts BPS dividend bits into the remainder, quotient bits in at the bottom
  always_comb begin
    logic [PW-1:0] w;
    logic [DW-1:0] r;
    logic [DW:0]   t;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        w = PW'(in_num);
        r = '0;
      end else begin
        w = wk[s-1];
        r = rm[s-1];
      end
      for (int k = 0; k < BPS; k++) begin
        t = {r, w[PW-1]};
        w = {w[PW-2:0], 1'b0};
        if (t >= {1'b0, div}) begin
          t    = t - {1'b0, div};
          w[0] = 1'b1;
        end
        r = t[DW-1:0];
      end
      wk_next[s] = w;
      rm_next[s] = r;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NS-2:0], in_valid};
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        wk[s] <= wk_next[s];
        rm[s] <= rm_next[s];
        sd[s] <= (s == 0) ? in_side : sd[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign out_valid = v[NS-1];
  assign out_quo   = wk[NS-1][NW-1:0];
  assign out_rem   = rm[NS-1];
  assign out_side  = sd[NS-1];

endmodule

// ----- rtl/core/spl_merge.sv -----
// Final stages: stripe times block size plus remainder, and parity rotation.
module spl_merge
  import spl_pkg::*;
#(
  parameter int W = OFFSET_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [W-1:0]    stripe,
  input  logic [CI_W-1:0] unit,
  input  logic [NC_W-1:0] smod,
  input  logic [BS_W-1:0] rem,
  input  logic [BS_W-1:0] bs,
  input  logic [NC_W-1:0] ncomp,
  output logic            out_valid,
  output logic [CI_W-1:0] comp,
  output logic [W-1:0]    coff
);

  localparam int LW = (W + 1) / 2;
  localparam int HW = W - LW;
  localparam int SUMW = W + BS_W;

  logic              v1;
  logic [LW+BS_W-1:0] plo;
  logic [HW+BS_W-1:0] phi;
  logic [BS_W-1:0]   rem1;
  logic [CI_W-1:0]   comp1;
  logic [NC_W:0]     rot;
  logic [NC_W:0]     rot_adj;
  logic [SUMW-1:0]   sum;

  // Rotation: unit + n - (stripe mod n), one conditional subtract
  always_comb begin
    rot     = (NC_W+1)'(unit) + (NC_W+1)'(ncomp) - (NC_W+1)'(smod);
    rot_adj = (rot >= (NC_W+1)'(ncomp)) ? rot - (NC_W+1)'(ncomp) : rot;
  end

  // Stage one: split product, rotation
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plo   <= stripe[LW-1:0] * bs;
      phi   <= stripe[W-1:LW] * bs;
      rem1  <= rem;
      comp1 <= rot_adj[CI_W-1:0];
    end
  end

  // Stage two: recombine partial products, add in-block remainder
  assign sum = SUMW'(plo) + (SUMW'(phi) << LW) + SUMW'(rem1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      comp <= comp1;
      coff <= sum[W-1:0];
    end
  end

endmodule

// ----- rtl/core/striped_parity_layout_locator_core.sv -----
// Pipeline: three 8-bit/stage dividers (block, stripe, rotation), then the merge stages.
// Throughput: one request per cycle; a stalled output holds the whole pipeline.
// Reset: clears all valid bits; num_components returns to 2, block_size to 65536.
// Register writes clamp num_components to 2..64 and a zero block_size to 1.
module striped_parity_layout_locator_core
  import spl_pkg::*;
#(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [spl_pkg::IDX_W-1:0] wr_index,
  input  logic [spl_pkg::CFG_W-1:0] wr_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OFFSET_WIDTH-1:0] byte_offset,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [spl_pkg::CI_W-1:0] component_index,
  output logic [OFFSET_WIDTH-1:0] component_offset
);

  localparam int W = OFFSET_WIDTH;

  logic [NC_W-1:0] ncomp;
  logic [BS_W-1:0] bsize;
  logic [NC_W-1:0] wr_nc;
  logic            en;

  logic            d1_valid;
  logic [W-1:0]    d1_block;
  logic [BS_W-1:0] d1_rem;
  logic            d2_valid;
  logic [W-1:0]    d2_stripe;
  logic [CI_W-1:0] d2_unit;
  logic [BS_W-1:0] d2_side;
  logic            d3_valid;
  logic [NC_W-1:0] d3_smod;
  logic [W+CI_W+BS_W-1:0] d3_side;

  // Config registers hold already-clamped values
  assign wr_nc = wr_data[NC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ncomp <= RESET_COMPONENTS;
      bsize <= RESET_BLOCK_SIZE;
    end else if (wr_en) begin
      case (wr_index)
        REG_NUM_COMPONENTS: begin
          if (wr_nc < MIN_COMPONENTS)       ncomp <= MIN_COMPONENTS;
          else if (wr_nc > MAX_COMPONENTS)  ncomp <= MAX_COMPONENTS;
          else                              ncomp <= wr_nc;
        end
        REG_BLOCK_SIZE: begin
          bsize <= (wr_data[BS_W-1:0] == '0) ? BS_W'(1) : wr_data[BS_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless a finished request is held at the output
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Block number and offset within the block
  spl_div #(.NW(W), .DW(BS_W), .BPS(DIV_BPS), .SW(1)) u_div_block (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_valid), .in_num(byte_offset), .in_side(1'b0), .div(bsize),
    .out_valid(d1_valid), .out_quo(d1_block), .out_rem(d1_rem), .out_side()
  );

  // Stripe and data unit within the stripe
  spl_div #(.NW(W), .DW(CI_W), .BPS(DIV_BPS), .SW(BS_W)) u_div_stripe (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(d1_valid), .in_num(d1_block), .in_side(d1_rem),
    .div(CI_W'(ncomp - NC_W'(1))),
    .out_valid(d2_valid), .out_quo(d2_stripe), .out_rem(d2_unit), .out_side(d2_side)
  );

  // Stripe mod component count for parity rotation
  spl_div #(.NW(W), .DW(NC_W), .BPS(DIV_BPS), .SW(W+CI_W+BS_W)) u_div_rot (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(d2_valid), .in_num(d2_stripe), .in_side({d2_stripe, d2_unit, d2_side}),
    .div(ncomp),
    .out_valid(d3_valid), .out_quo(), .out_rem(d3_smod), .out_side(d3_side)
  );

  // Component offset and index
  spl_merge #(.W(W)) u_merge (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(d3_valid),
    .stripe(d3_side[W+CI_W+BS_W-1:CI_W+BS_W]),
    .unit(d3_side[CI_W+BS_W-1:BS_W]),
    .smod(d3_smod),
    .rem(d3_side[BS_W-1:0]),
    .bs(bsize), .ncomp(ncomp),
    .out_valid(out_valid), .comp(component_index), .coff(component_offset)
  );

endmodule
